/* rtl/lbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Learning bridge forwarding package
// Port counts, configuration register indexes and the active port mask
// function shared by the bridge forwarding logic.
// ----------------------------------------------------------------------------
package lbf_pkg;

    localparam int NUM_PORTS      = 8;
    localparam int PORT_BITS      = 3;
    localparam int PORT_CNT_BITS  = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    typedef logic [NUM_PORTS-1:0]      port_mask_t;
    typedef logic [PORT_BITS-1:0]      port_num_t;
    typedef logic [PORT_CNT_BITS-1:0]  port_cnt_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_PORTS_IN_USE      = 2'd0;
    localparam cfg_index_t CFG_BLOCKED_PORT_MASK = 2'd1;

    function automatic port_mask_t active_mask(input port_cnt_t ports_in_use);
        logic [NUM_PORTS:0] ones;
        port_cnt_t          n;
        n = (ports_in_use > port_cnt_t'(NUM_PORTS)) ? port_cnt_t'(NUM_PORTS) : ports_in_use;
        ones = ((NUM_PORTS+1)'(1) << n) - (NUM_PORTS+1)'(1);
        return ones[NUM_PORTS-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/learning_bridge_forwarding.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Learning bridge forwarding
// Forwarding decision and source learning for a transparent bridge.
// ----------------------------------------------------------------------------
// Each request carries the ingress port and the source and destination station
// addresses of one frame; each result gives the egress port mask and the known,
// learned and full flags. The forwarding table sits in one memory with a
// registered read. A request scans every valid entry once, one entry per cycle,
// matching destination and source together, then learns a new source at the
// end of the table while there is room. A request from a blocked or inactive
// port skips the scan. The next request is accepted in the cycle after the
// result is registered. A finished result is held in an output register, so
// the next request is taken while it waits; a result that finds the output
// register still full waits until it is taken.
// Configuration must be written only while the block is idle.
module learning_bridge_forwarding #(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire lbf_pkg::cfg_index_t   cfg_wr_index,
    input  wire lbf_pkg::cfg_data_t    cfg_wr_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lbf_pkg::port_num_t    s_ingress_port,
    input  wire logic [ADDR_BITS-1:0]  s_source_station,
    input  wire logic [ADDR_BITS-1:0]  s_dest_station,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lbf_pkg::port_mask_t        m_egress_mask,
    output logic                       m_dest_known,
    output logic                       m_source_learned,
    output logic                       m_table_full
);

    import lbf_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = ADDR_BITS + PORT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    port_cnt_t              ports_in_use_reg;
    port_mask_t             blocked_reg;
    port_num_t              ingress_reg;
    logic [ADDR_BITS-1:0]   src_reg;
    logic [ADDR_BITS-1:0]   dst_reg;
    port_mask_t             usable_reg;
    logic                   drop_reg;
    logic [CNT_W-1:0]       issue_idx_reg;
    logic                   rd_vld_reg;
    logic                   dst_hit_reg;
    port_num_t              dst_port_reg;
    logic                   src_hit_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   m_valid_reg;
    port_mask_t             egress_reg;
    logic                   known_reg;
    logic                   learned_reg;
    logic                   full_reg;

    logic [ENTRY_W-1:0]     rd_data;
    logic [ADDR_BITS-1:0]   rd_station;
    port_num_t              rd_port;
    port_mask_t             usable_in;
    port_mask_t             ingress_bit;
    port_mask_t             dst_bit;
    port_mask_t             egress_next;
    logic                   room;
    logic                   learn_next;
    logic                   full_next;
    logic                   out_free;
    logic                   wr_en;

    lbf_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({src_reg, ingress_reg}),
        .rd_addr (issue_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_station = rd_data[ENTRY_W-1:PORT_BITS];
    assign rd_port    = rd_data[PORT_BITS-1:0];

    assign usable_in   = active_mask(ports_in_use_reg) & ~blocked_reg;
    assign ingress_bit = port_mask_t'(1) << ingress_reg;
    assign dst_bit     = port_mask_t'(1) << dst_port_reg;
    assign room        = count_reg < CNT_W'(TABLE_DEPTH);

    always_comb begin
        if (drop_reg) begin
            egress_next = '0;
        end else if (dst_hit_reg) begin
            egress_next = (dst_bit == ingress_bit) ? port_mask_t'(0) : (dst_bit & usable_reg);
        end else begin
            egress_next = usable_reg & ~ingress_bit;
        end
    end

    assign learn_next = !drop_reg && !src_hit_reg && room;
    assign full_next  = !drop_reg && !src_hit_reg && !room;
    assign out_free   = !m_valid_reg || m_ready;
    assign wr_en      = (state_reg == ST_DONE) && out_free && learn_next;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_egress_mask    = egress_reg;
    assign m_dest_known     = known_reg;
    assign m_source_learned = learned_reg;
    assign m_table_full     = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ports_in_use_reg <= port_cnt_t'(NUM_PORTS);
            blocked_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_PORTS_IN_USE: begin
                    ports_in_use_reg <= cfg_wr_data[PORT_CNT_BITS-1:0];
                end
                CFG_BLOCKED_PORT_MASK: begin
                    blocked_reg <= cfg_wr_data[NUM_PORTS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            dst_hit_reg   <= 1'b0;
            src_hit_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ingress_reg   <= s_ingress_port;
                        src_reg       <= s_source_station;
                        dst_reg       <= s_dest_station;
                        usable_reg    <= usable_in;
                        drop_reg      <= !usable_in[s_ingress_port];
                        issue_idx_reg <= '0;
                        rd_vld_reg    <= 1'b0;
                        dst_hit_reg   <= 1'b0;
                        src_hit_reg   <= 1'b0;
                        state_reg     <= usable_in[s_ingress_port] ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (issue_idx_reg < count_reg) begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                        rd_vld_reg    <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (rd_vld_reg) begin
                        if (!dst_hit_reg && rd_station == dst_reg) begin
                            dst_hit_reg  <= 1'b1;
                            dst_port_reg <= rd_port;
                        end
                        if (rd_station == src_reg) begin
                            src_hit_reg <= 1'b1;
                        end
                    end
                    if (issue_idx_reg == count_reg && !rd_vld_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        egress_reg  <= egress_next;
                        known_reg   <= !drop_reg && dst_hit_reg;
                        learned_reg <= learn_next;
                        full_reg    <= full_next;
                        if (learn_next) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("Table entry count exceeds the table depth.");

    a_learn_full_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(learned_reg && full_reg))
        else $error("A result reports both a learned source and a full table.");

    a_no_hairpin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> (egress_next & ingress_bit) == '0)
        else $error("A frame would leave on its own ingress port.");

    a_learn_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("A learned source did not advance the entry count.");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> issue_idx_reg <= count_reg)
        else $error("The table scan ran past the learned entries.");

endmodule
`default_nettype wire

/* rtl/lbf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Forwarding table memory
// Single port write, single port read memory with a registered read.
// ----------------------------------------------------------------------------
module lbf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 19
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire
